[rtl/core/whole_word_keyword_matcher_assert.svh]
// assertion macros shared by the keyword matcher rtl
`ifndef WHOLE_WORD_KEYWORD_MATCHER_ASSERT_SVH
`define WHOLE_WORD_KEYWORD_MATCHER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// property checked every cycle outside reset
`define WWKM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");
// consequent checked in the cycle after the antecedent
`define WWKM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");
`else
`define WWKM_ASSERT(lbl, prop)
`define WWKM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/core/wwkm_pkg.sv]
// shared types, constants and helper functions of the keyword matcher
package wwkm_pkg;

  localparam int MAX_KEYWORD_DEF   = 32;
  localparam int POSITION_BITS_DEF = 32;
  localparam int KEY_REG_NUM       = 4;
  localparam int KEY_BYTES         = 32;
  localparam int KEY_LEN_RESET     = 1;
  localparam int OUT_W             = 32;
  localparam int RUN_MAX           = 3;
  localparam int FIFO_DEPTH        = 8;
  localparam int FIFO_PTR_W        = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W        = FIFO_PTR_W + 1;

  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [OUT_W-1:0] TOTAL_MAX = '1;

  typedef logic [7:0] byte_t;

  typedef enum logic [2:0] {
    REG_KEY_LEN   = 3'd0,
    REG_KEY_0_7   = 3'd1,
    REG_KEY_8_15  = 3'd2,
    REG_KEY_16_23 = 3'd3,
    REG_KEY_24_31 = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic             is_summary;
    logic [OUT_W-1:0] hit_offset;
    logic [OUT_W-1:0] hit_total;
    logic             last_of_run;
  } result_t;

  // up to three results produced by one text byte, packed from slot 0
  typedef struct packed {
    logic [1:0]                count;
    result_t [RUN_MAX-1:0]     items;
  } push_t;

  function automatic logic is_ascii_alpha(byte_t c);
    return c inside {[CH_LOWER_A:CH_LOWER_Z], [CH_UPPER_A:CH_UPPER_Z]};
  endfunction

  function automatic logic [OUT_W-1:0] sat_inc(logic [OUT_W-1:0] v, logic en);
    return (en && (v != TOTAL_MAX)) ? v + OUT_W'(1) : v;
  endfunction

endpackage

[rtl/core/wwkm_in_if.sv]
// text byte request channel
interface wwkm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

[rtl/core/wwkm_out_if.sv]
// result request channel
interface wwkm_out_if;
  logic        valid;
  logic        ready;
  logic        is_summary;
  logic [31:0] hit_offset;
  logic [31:0] hit_total;
  logic        last_of_run;

  modport source (output valid, output is_summary, output hit_offset, output hit_total,
                  output last_of_run, input ready);
  modport sink   (input valid, input is_summary, input hit_offset, input hit_total,
                  input last_of_run, output ready);
endinterface

[rtl/core/wwkm_cfg_if.sv]
// configuration write channel
interface wwkm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  addr;
  logic [63:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

[rtl/core/wwkm_cfg_regs.sv]
// configuration registers and the registered, length-aligned keyword
module wwkm_cfg_regs
  import wwkm_pkg::*;
#(
  parameter int MAX_KEYWORD = MAX_KEYWORD_DEF,
  localparam int LEN_W      = $clog2(MAX_KEYWORD + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  wwkm_cfg_if.sink         cfg_ch,
  output logic [LEN_W-1:0] key_len,
  output byte_t            key_rev [MAX_KEYWORD]
);

  logic [5:0]       kl_r;
  logic [63:0]      kw_r [KEY_REG_NUM];
  byte_t            key_bytes [KEY_BYTES];
  logic [LEN_W-1:0] len_nxt;
  byte_t            rev_nxt [MAX_KEYWORD];
  logic [LEN_W-1:0] key_len_r;
  byte_t            key_rev_r [MAX_KEYWORD];

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kl_r <= 6'(KEY_LEN_RESET);
      for (int r = 0; r < KEY_REG_NUM; r++) kw_r[r] <= '0;
    end else if (cfg_ch.valid) begin
      case (reg_idx_t'(cfg_ch.addr))
        REG_KEY_LEN:   kl_r    <= cfg_ch.data[5:0];
        REG_KEY_0_7:   kw_r[0] <= cfg_ch.data;
        REG_KEY_8_15:  kw_r[1] <= cfg_ch.data;
        REG_KEY_16_23: kw_r[2] <= cfg_ch.data;
        REG_KEY_24_31: kw_r[3] <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // keyword byte k lands at window slot len-1-k, newest byte first
  always_comb begin
    logic [5:0] k;
    for (int m = 0; m < KEY_BYTES; m++) key_bytes[m] = kw_r[m >> 3][(m & 7) * 8 +: 8];
    len_nxt = (32'(kl_r) > MAX_KEYWORD) ? LEN_W'(MAX_KEYWORD) : LEN_W'(kl_r);
    for (int j = 0; j < MAX_KEYWORD; j++) begin
      k = 6'(len_nxt) - 6'(j) - 6'd1;
      rev_nxt[j] = (LEN_W'(j) < len_nxt) ? key_bytes[k[4:0]] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_len_r <= LEN_W'(KEY_LEN_RESET);
      for (int j = 0; j < MAX_KEYWORD; j++) key_rev_r[j] <= '0;
    end else begin
      key_len_r <= len_nxt;
      key_rev_r <= rev_nxt;
    end
  end

  assign key_len = key_len_r;
  assign key_rev = key_rev_r;

endmodule

[rtl/core/wwkm_match_core.sv]
// input register, byte window, position and hit counting
module wwkm_match_core
  import wwkm_pkg::*;
#(
  parameter int MAX_KEYWORD   = MAX_KEYWORD_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  localparam int LEN_W        = $clog2(MAX_KEYWORD + 1),
  localparam int HIST_D       = MAX_KEYWORD + 1,
  localparam int EXT_W        = (POSITION_BITS > OUT_W) ? POSITION_BITS : OUT_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  wwkm_in_if.sink               in_ch,
  input  logic [LEN_W-1:0]      key_len,
  input  byte_t                 key_rev [MAX_KEYWORD],
  input  logic [FIFO_CNT_W-1:0] fifo_space,
  output push_t                 push
);

  `include "whole_word_keyword_matcher_assert.svh"

  logic                     in_valid_r;
  byte_t                    text_r;
  logic                     eot_r;
  byte_t                    hist_r [HIST_D];
  logic [POSITION_BITS-1:0] pos_r;
  logic [OUT_W-1:0]         total_r;

  byte_t                    win_nxt [HIST_D];
  logic [MAX_KEYWORD-1:0]   eq_prev, eq_new;
  logic [POSITION_BITS-1:0] len_p, seen, diff_prev, diff_new;
  logic [EXT_W-1:0]         ext_prev, ext_new;
  logic                     hit_prev, hit_new, fire;
  logic [OUT_W-1:0]         tot1, tot2;
  result_t                  res_prev, res_new, res_sum;
  result_t [RUN_MAX-1:0]    items;
  logic [1:0]               n_res;

  assign win_nxt[0] = text_r;
  for (genvar j = 1; j < HIST_D; j++) begin : g_win
    assign win_nxt[j] = hist_r[j-1];
  end

  always_comb begin
    for (int j = 0; j < MAX_KEYWORD; j++) begin
      eq_prev[j] = (LEN_W'(j) >= key_len) || (hist_r[j] == key_rev[j]);
      eq_new[j]  = (LEN_W'(j) >= key_len) || (win_nxt[j] == key_rev[j]);
    end
  end

  assign len_p = POSITION_BITS'(key_len);
  assign seen  = (&pos_r) ? pos_r : pos_r + POSITION_BITS'(1);

  // hit ending on the previous byte, confirmed by a non-letter now
  assign hit_prev = (key_len != '0) && (pos_r >= len_p) && (&eq_prev) &&
                    !((pos_r > len_p) && is_ascii_alpha(hist_r[key_len])) &&
                    !is_ascii_alpha(text_r);
  // hit ending on the final byte, closed by the end of text
  assign hit_new  = eot_r && (key_len != '0) && (seen >= len_p) && (&eq_new) &&
                    !((seen > len_p) && is_ascii_alpha(win_nxt[key_len]));

  assign diff_prev = pos_r - len_p;
  assign diff_new  = seen - len_p;
  assign ext_prev  = EXT_W'(diff_prev);
  assign ext_new   = EXT_W'(diff_new);

  assign tot1 = sat_inc(total_r, hit_prev);
  assign tot2 = sat_inc(tot1, hit_new);

  always_comb begin
    res_prev = '{is_summary: 1'b0, hit_offset: ext_prev[OUT_W-1:0], hit_total: tot1,
                 last_of_run: 1'b0};
    res_new  = '{is_summary: 1'b0, hit_offset: ext_new[OUT_W-1:0], hit_total: tot2,
                 last_of_run: 1'b0};
    res_sum  = '{is_summary: 1'b1, hit_offset: '0, hit_total: tot2, last_of_run: 1'b0};
    items = '0;
    n_res = 2'd0;
    if (hit_prev) begin
      items[n_res] = res_prev;
      n_res = n_res + 2'd1;
    end
    if (hit_new) begin
      items[n_res] = res_new;
      n_res = n_res + 2'd1;
    end
    if (eot_r) begin
      items[n_res] = res_sum;
      n_res = n_res + 2'd1;
    end
    if (n_res != 2'd0) items[n_res - 2'd1].last_of_run = 1'b1;
  end

  // byte is retired only when its whole run fits in the result queue
  assign fire         = in_valid_r && (FIFO_CNT_W'(n_res) <= fifo_space);
  assign in_ch.ready  = !in_valid_r || fire;
  assign push.count   = fire ? n_res : 2'd0;
  assign push.items   = items;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      text_r <= in_ch.text_byte;
      eot_r  <= in_ch.end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      total_r <= '0;
      for (int j = 0; j < HIST_D; j++) hist_r[j] <= '0;
    end else if (fire) begin
      if (eot_r) begin
        pos_r   <= '0;
        total_r <= '0;
        for (int j = 0; j < HIST_D; j++) hist_r[j] <= '0;
      end else begin
        pos_r   <= seen;
        total_r <= tot2;
        hist_r  <= win_nxt;
      end
    end
  end

  `WWKM_ASSERT_NEXT(a_eot_clears, fire && eot_r, pos_r == '0 && total_r == '0)
  `WWKM_ASSERT_NEXT(a_total_no_wrap, fire && !eot_r, total_r >= $past(total_r))
  `WWKM_ASSERT(a_run_marked, (push.count != 2'd0) |-> push.items[push.count - 2'd1].last_of_run)

endmodule

[rtl/core/wwkm_result_fifo.sv]
// result queue taking up to three results a cycle, draining one a cycle while out_ch is ready
module wwkm_result_fifo
  import wwkm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  push_t                 push,
  output logic [FIFO_CNT_W-1:0] space,
  wwkm_out_if.source            out_ch
);

  `include "whole_word_keyword_matcher_assert.svh"

  result_t                 mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0]   count_r, count_nxt;
  logic                    pop;
  result_t                 head;

  assign space = FIFO_CNT_W'(FIFO_DEPTH) - count_r;
  assign pop   = out_ch.valid && out_ch.ready;
  assign head  = mem_r[rd_ptr_r];

  assign out_ch.valid       = (count_r != '0);
  assign out_ch.is_summary  = head.is_summary;
  assign out_ch.hit_offset  = head.hit_offset;
  assign out_ch.hit_total   = head.hit_total;
  assign out_ch.last_of_run = head.last_of_run;

  assign wr_ptr_nxt = wr_ptr_r + FIFO_PTR_W'(push.count);
  assign rd_ptr_nxt = rd_ptr_r + FIFO_PTR_W'(pop);
  assign count_nxt  = count_r + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < RUN_MAX; i++) begin
      if (2'(i) < push.count) mem_r[FIFO_PTR_W'(wr_ptr_r + FIFO_PTR_W'(i))] <= push.items[i];
    end
  end

  `WWKM_ASSERT(a_cnt_bound, count_r <= FIFO_CNT_W'(FIFO_DEPTH))
  `WWKM_ASSERT(a_push_fits, FIFO_CNT_W'(push.count) <= space)
  `WWKM_ASSERT(a_ptr_gap, FIFO_PTR_W'(wr_ptr_r - rd_ptr_r) == count_r[FIFO_PTR_W-1:0])

endmodule

[rtl/core/whole_word_keyword_matcher.sv]
// top level of the whole-word keyword matcher
// usage:
//   in_ch carries one text byte per request, end_of_text set on the final byte
//   cfg_ch writes the keyword length (index 0) and the four keyword byte words
//   (indexes 1 to 4); it is always ready and should only be used while idle
//   out_ch returns hit reports (offset of the hit start, running total) and,
//   on the final byte, a summary with the text's total; last_of_run marks the
//   last result caused by a byte
// timing:
//   a byte sits in the input register, where the keyword window
//   compare and boundary checks run, and its results enter an 8-entry queue;
//   the first result is visible on out_ch once it has been written into the queue
//   one byte per cycle is taken while the queue has room for that byte's run
//   (up to three results); results leave at one per cycle while out_ch is ready
// reset and stalls:
//   reset clears position, total, window, queue and sets keyword length to 1;
//   a stalled out_ch fills the queue, then in_ch ready drops until room frees
module whole_word_keyword_matcher
  import wwkm_pkg::*;
#(
  parameter int MAX_KEYWORD   = MAX_KEYWORD_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  wwkm_in_if.sink    in_ch,
  wwkm_out_if.source out_ch,
  wwkm_cfg_if.sink   cfg_ch
);

  localparam int LEN_W = $clog2(MAX_KEYWORD + 1);

  // keyword length clipped to the window and keyword bytes in window order
  logic [LEN_W-1:0]      key_len;
  byte_t                 key_rev [MAX_KEYWORD];
  // results of one byte headed for the queue, and the room left there
  push_t                 push;
  logic [FIFO_CNT_W-1:0] fifo_space;

  wwkm_cfg_regs #(
    .MAX_KEYWORD (MAX_KEYWORD)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_ch  (cfg_ch),
    .key_len (key_len),
    .key_rev (key_rev)
  );

  wwkm_match_core #(
    .MAX_KEYWORD   (MAX_KEYWORD),
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .key_len    (key_len),
    .key_rev    (key_rev),
    .fifo_space (fifo_space),
    .push       (push)
  );

  // output register stage: queue parts the receiver from the matcher
  wwkm_result_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .space  (fifo_space),
    .out_ch (out_ch)
  );

endmodule

[dv/wwkm_checker.sv]
// checker: predicts keyword matcher results from the observed requests and compares them
module wwkm_checker
  import wwkm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  wwkm_in_if   in_ch,
  wwkm_out_if  out_ch,
  wwkm_cfg_if  cfg_ch,
  output int   mismatches,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW_DEPTH = MAX_KEYWORD_DEF + 1;
  localparam int REPORT_LIMIT = 100;

  logic [5:0]  key_len_reg;
  logic [63:0] key_words [KEY_REG_NUM];
  byte_t       window [WINDOW_DEPTH];
  logic [31:0] text_pos;
  logic [31:0] hit_count;
  result_t     expected_results [$];
  int          fail_count = 0;
  int          waiting = 0;
  int          results_seen = 0;

  assign mismatches  = fail_count;
  assign outstanding = waiting;

  function automatic logic is_alpha(byte_t c);
    return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z);
  endfunction

  function automatic byte_t key_at(int k);
    return key_words[k / 8][8 * (k % 8) +: 8];
  endfunction

  function automatic int active_len();
    return (key_len_reg > MAX_KEYWORD_DEF) ? MAX_KEYWORD_DEF : int'(key_len_reg);
  endfunction

  // keyword ending at window[0] with a non-letter (or text start) before it
  function automatic logic tail_match(int len, logic [31:0] seen);
    if (len == 0 || seen < 32'(len)) return 1'b0;
    for (int k = 0; k < len; k++) begin
      if (window[len - 1 - k] != key_at(k)) return 1'b0;
    end
    if (seen > 32'(len) && is_alpha(window[len])) return 1'b0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what);
    if (fail_count < REPORT_LIMIT) $display("%0t: mismatch on result %0d: %s",
                                            $time, results_seen, what);
    fail_count++;
  endtask

  task automatic push_result(logic summary, logic [31:0] offset);
    result_t r;
    r.is_summary  = summary;
    r.hit_offset  = offset;
    r.hit_total   = hit_count;
    r.last_of_run = 1'b0;
    expected_results.push_back(r);
  endtask

  task automatic push_hit(logic [31:0] offset);
    if (hit_count != '1) hit_count++;
    push_result(1'b0, offset);
  endtask

  task automatic predict_text_byte(byte_t b, logic final_byte);
    int          len;
    int          run_start;
    logic [31:0] seen;
    result_t     r;
    len = active_len();
    run_start = expected_results.size();
    // hit that ended on the previous byte, confirmed by this one
    if (!is_alpha(b) && tail_match(len, text_pos)) push_hit(text_pos - 32'(len));
    for (int i = WINDOW_DEPTH - 1; i > 0; i--) window[i] = window[i - 1];
    window[0] = b;
    seen = (text_pos == '1) ? text_pos : text_pos + 32'd1;
    if (final_byte) begin
      if (tail_match(len, seen)) push_hit(seen - 32'(len));
      push_result(1'b1, '0);
      text_pos  = '0;
      hit_count = '0;
      foreach (window[i]) window[i] = '0;
    end else begin
      text_pos = seen;
    end
    if (expected_results.size() > run_start) begin
      r = expected_results.pop_back();
      r.last_of_run = 1'b1;
      expected_results.push_back(r);
    end
  endtask

  task automatic check_result();
    result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("nothing expected, got summary %0b offset %0d total %0d last %0b",
                                out_ch.is_summary, out_ch.hit_offset, out_ch.hit_total,
                                out_ch.last_of_run));
      return;
    end
    want = expected_results.pop_front();
    if (out_ch.is_summary !== want.is_summary)
      report_mismatch($sformatf("is_summary got %0b want %0b", out_ch.is_summary,
                                want.is_summary));
    if (out_ch.hit_offset !== want.hit_offset)
      report_mismatch($sformatf("hit_offset got %0d want %0d", out_ch.hit_offset,
                                want.hit_offset));
    if (out_ch.hit_total !== want.hit_total)
      report_mismatch($sformatf("hit_total got %0d want %0d", out_ch.hit_total,
                                want.hit_total));
    if (out_ch.last_of_run !== want.last_of_run)
      report_mismatch($sformatf("last_of_run got %0b want %0b", out_ch.last_of_run,
                                want.last_of_run));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      key_len_reg = KEY_LEN_RESET;
      foreach (key_words[i]) key_words[i] = '0;
      foreach (window[i]) window[i] = '0;
      text_pos  = '0;
      hit_count = '0;
      expected_results.delete();
    end else begin
      // results leave only after their byte has been taken, so check first
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        check_result();
        results_seen++;
      end
      if (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1) begin
        case (cfg_ch.addr)
          REG_KEY_LEN: key_len_reg = cfg_ch.data[5:0];
          REG_KEY_0_7, REG_KEY_8_15, REG_KEY_16_23, REG_KEY_24_31:
            key_words[cfg_ch.addr - REG_KEY_0_7] = cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
        predict_text_byte(in_ch.text_byte, in_ch.end_of_text);
    end
    waiting = expected_results.size();
  end

endmodule

[dv/tb_top.sv]
// testbench top: clock, reset, text and keyword stimulus and the verdict for the matcher
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import wwkm_pkg::*;

  localparam int RANDOM_ITEMS  = 340;  // random text bytes before the run winds down
  localparam int PHASE_ITEMS   = 45;   // text bytes per keyword setting
  localparam int SETTLE_CYCLES = 4;    // time for a byte with no result to leave the input register
  localparam int DRAIN_LIMIT   = 5000;
  localparam int NUM_SEPARATORS = 11;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   outstanding;
  int   in_idle_pct  = 0;
  int   out_idle_pct = 0;
  int   bytes_sent   = 0;

  // keyword as last written, and how many of its bytes are in use
  byte_t key_text [KEY_BYTES];
  int    key_used = KEY_LEN_RESET;

  // non-letters, several of them right beside the letter ranges, plus non-ascii
  byte_t separators [NUM_SEPARATORS] = '{
    8'h20,  // space
    8'h2e,  // period
    8'h40,  // just below upper-case a
    8'h5b,  // just above upper-case z
    8'h60,  // just below lower-case a
    8'h7b,  // just above lower-case z
    8'h00,
    8'h80,
    8'hff,
    8'h30,  // digit zero
    8'h0a   // newline
  };

  wwkm_in_if  in_ch ();
  wwkm_out_if out_ch ();
  wwkm_cfg_if cfg_ch ();

  whole_word_keyword_matcher dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // the checker watches all three channels and keeps the expected results
  wwkm_checker match_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_ch      (cfg_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin : watchdog
    #2_400_000;
    $display("FAIL");
    $finish;
  end

  // idle cycles before a request: drawn with the given chance, else none
  function automatic int draw_gap(int idle_pct);
    if ($urandom_range(99) < idle_pct) return $urandom_range(1, 8);
    return 0;
  endfunction

  function automatic byte_t random_letter();
    if ($urandom_range(1) == 1) return byte_t'($urandom_range(CH_LOWER_A, CH_LOWER_Z));
    return byte_t'($urandom_range(CH_UPPER_A, CH_UPPER_Z));
  endfunction

  // keyword bytes lean on a tiny alphabet so that near misses and overlaps happen
  function automatic byte_t pick_key_byte();
    case ($urandom_range(0, 5))
      0, 1, 2: return byte_t'($urandom_range(CH_LOWER_A, CH_LOWER_A + 2));
      3:       return random_letter();
      4:       return 8'h2d;  // dash, a non-letter that can overlap itself
      default: return byte_t'($urandom);
    endcase
  endfunction

  // result side: ready held low for a random stall before each request
  initial begin : result_sink
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        stall--;
      end else begin
        out_ch.ready = 1'b1;
        @(posedge clk);
        if (out_ch.valid === 1'b1) stall = draw_gap(out_idle_pct);
      end
    end
  end

  // one text byte request; valid stays high when the next byte follows with no gap
  task automatic send_text_byte(input byte_t b, input logic final_byte);
    int gap;
    gap = draw_gap(in_idle_pct);
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid       = 1'b1;
    in_ch.text_byte   = b;
    in_ch.end_of_text = final_byte;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    bytes_sent++;
  endtask

  task automatic send_bytes(input byte_t txt[$]);
    foreach (txt[i]) send_text_byte(txt[i], i == txt.size() - 1);
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_text_byte(s[i], i == s.len() - 1);
  endtask

  // hold off the sender until every expected result is back, then let the
  // last byte leave the input register
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] value);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.addr  = idx;
    cfg_ch.data  = value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // write length and all four keyword words from key_text, only once idle
  task automatic load_keyword(input logic [5:0] len_val);
    logic [63:0] word;
    wait_idle();
    cfg_write(REG_KEY_LEN, 64'(len_val));
    for (int r = 0; r < KEY_REG_NUM; r++) begin
      for (int k = 0; k < 8; k++) word[8 * k +: 8] = key_text[8 * r + k];
      cfg_write(reg_idx_t'(REG_KEY_0_7 + r), word);
    end
    // lengths above the keyword store act as a full-length keyword
    key_used = (len_val > KEY_BYTES) ? KEY_BYTES : int'(len_val);
  endtask

  task automatic set_key_string(input string s);
    for (int k = 0; k < KEY_BYTES; k++) key_text[k] = (k < s.len()) ? s[k] : 8'h00;
    load_keyword(6'(s.len()));
  endtask

  // indexes past the last register must change nothing
  task automatic write_unused_regs();
    for (int i = REG_KEY_24_31 + 1; i < 8; i++) cfg_write(3'(i), {$urandom, $urandom});
  endtask

  // a text made of keyword copies, near misses, separators, letters and noise
  task automatic send_random_text(input int max_chunks);
    byte_t txt[$];
    int    cut;
    int    flip;
    repeat ($urandom_range(1, max_chunks)) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: for (int k = 0; k < key_used; k++) txt.push_back(key_text[k]);
        4: begin
          // keyword prefix only
          cut = (key_used > 1) ? $urandom_range(1, key_used - 1) : key_used;
          for (int k = 0; k < cut; k++) txt.push_back(key_text[k]);
        end
        5: begin
          // keyword with one byte changed
          flip = (key_used > 0) ? $urandom_range(0, key_used - 1) : 0;
          for (int k = 0; k < key_used; k++)
            txt.push_back((k == flip) ? pick_key_byte() : key_text[k]);
        end
        6, 7: txt.push_back(separators[$urandom_range(0, NUM_SEPARATORS - 1)]);
        8: repeat ($urandom_range(1, 3)) txt.push_back(random_letter());
        default: txt.push_back(byte_t'($urandom));
      endcase
    end
    if (txt.size() == 0) txt.push_back(byte_t'($urandom));
    send_bytes(txt);
  endtask

  initial begin : stimulus
    int         phase;
    int         random_start;
    int         phase_start;
    logic [5:0] len_val;

    in_ch.valid       = 1'b0;
    in_ch.text_byte   = '0;
    in_ch.end_of_text = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.addr       = REG_KEY_LEN;
    cfg_ch.data       = '0;
    foreach (key_text[k]) key_text[k] = 8'h00;
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // ---- directed part ----
    // reset keyword is a single zero byte, compared like any other byte
    send_bytes('{8'h00});
    // zero after a letter is no hit, the one that ends the text is
    send_bytes('{CH_LOWER_A, 8'h00, 8'h00});

    // last byte confirms one hit and ends another: three results in one run
    set_key_string(".");
    send_string("..");

    // overlapping occurrences of a self-overlapping non-letter keyword
    set_key_string("--");
    send_string("---");

    // whole word at text start and end, letters and near-letter bytes around it
    set_key_string("cat");
    send_string("cat");
    send_string("@cat{catZ");
    send_bytes('{8'hff, 8'h63, 8'h61, 8'h74});  // non-ascii byte, then the keyword

    // zero length never hits, the summary still comes
    wait_idle();
    write_unused_regs();
    load_keyword(6'd0);
    send_string("cat");

    // ---- random part ----
    phase = 0;
    random_start = bytes_sent;
    while (bytes_sent - random_start < RANDOM_ITEMS) begin
      for (int k = 0; k < KEY_BYTES; k++) key_text[k] = pick_key_byte();
      case (phase)
        0: len_val = 6'd63;  // largest register value
        1: len_val = 6'd0;
        2: len_val = 6'd32;
        default: begin
          case ($urandom_range(0, 9))
            0:       len_val = 6'd0;
            1:       len_val = 6'($urandom_range(33, 63));
            2:       len_val = 6'($urandom_range(7, 32));
            default: len_val = 6'($urandom_range(1, 6));
          endcase
        end
      endcase
      load_keyword(len_val);
      write_unused_regs();

      // every fourth setting runs with no idling on either side
      if (phase % 4 == 0) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct  = $urandom_range(0, 3) * 33;
        out_idle_pct = $urandom_range(0, 3) * 33;
      end

      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_ITEMS &&
             bytes_sent - random_start < RANDOM_ITEMS) begin
        send_random_text((key_used > 8) ? 2 : 6);
        // now and then the sender waits for every result before going on
        if ($urandom_range(0, 9) == 0) wait_idle();
      end
      phase++;
    end

    // ---- wind down ----
    @(negedge clk);
    in_ch.valid = 1'b0;
    for (int n = 0; n < DRAIN_LIMIT && outstanding != 0; n++) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[whole_word_keyword_matcher.f]
+incdir+rtl/core
rtl/core/wwkm_pkg.sv
rtl/core/wwkm_in_if.sv
rtl/core/wwkm_out_if.sv
rtl/core/wwkm_cfg_if.sv
rtl/core/wwkm_cfg_regs.sv
rtl/core/wwkm_match_core.sv
rtl/core/wwkm_result_fifo.sv
rtl/core/whole_word_keyword_matcher.sv
dv/wwkm_checker.sv
dv/tb_top.sv
